### design/u8bmp_pkg.sv
// Package with the types and constants shared by the UTF-8 to BMP decoder.
`default_nettype none

package u8bmp_pkg;

    localparam logic [15:0] C_REPLACEMENT = 16'hFFFD;
    localparam logic [7:0]  C_CONT_MASK   = 8'hC0;
    localparam logic [7:0]  C_CONT_CODE   = 8'h80;
    localparam logic [7:0]  C_LEAD2_MASK  = 8'hE0;
    localparam logic [7:0]  C_LEAD2_CODE  = 8'hC0;
    localparam logic [7:0]  C_LEAD3_MASK  = 8'hF0;
    localparam logic [7:0]  C_LEAD3_CODE  = 8'hE0;

    // Number of continuation bytes still owed by an open sequence.
    localparam logic [1:0]  C_PEND_NONE   = 2'd0;
    localparam logic [1:0]  C_PEND_ONE    = 2'd1;
    localparam logic [1:0]  C_PEND_TWO    = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_byte_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
    } t_unit_item;

endpackage

`default_nettype wire

### design/u8bmp_if.sv
// Valid/ready channel interfaces for the byte input and the code unit output.
`default_nettype none

interface u8bmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8bmp_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_replacement;

    modport source (output valid, output code_unit, output is_replacement, input ready);
    modport sink   (input valid, input code_unit, input is_replacement, output ready);
endinterface

`default_nettype wire

### design/u8bmp_in_reg.sv
// Input register that holds one accepted byte until the decode step takes it.
`default_nettype none

module u8bmp_in_reg
    import u8bmp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_byte_item i_item,
    input  wire        i_advance,
    output logic       o_valid,
    output t_byte_item o_item
);

    logic       r_valid;
    logic       n_valid;
    t_byte_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### design/u8bmp_step.sv
// Decode state and the combinational step that turns one byte into zero or one code unit.
`default_nettype none

module u8bmp_step
    import u8bmp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_fire,
    input  t_byte_item i_item,
    output logic       o_res_valid,
    output t_unit_item o_res
);

    logic [15:0] r_partial;
    logic [15:0] n_partial;
    logic [1:0]  r_pending;
    logic [1:0]  n_pending;
    logic [7:0]  byte_in;
    logic        is_cont;

    assign byte_in = i_item.in_byte;
    assign is_cont = (byte_in & C_CONT_MASK) == C_CONT_CODE;

    always_comb begin
        n_partial   = r_partial;
        n_pending   = r_pending;
        o_res_valid = 1'b0;
        o_res       = '{code_unit: 16'h0000, is_replacement: 1'b0};

        if (r_pending != C_PEND_NONE) begin
            if (is_cont) begin
                n_partial = {r_partial[9:0], byte_in[5:0]};
                n_pending = r_pending - 2'd1;
                if (r_pending == C_PEND_ONE) begin
                    o_res_valid = 1'b1;
                    o_res       = '{code_unit: n_partial, is_replacement: 1'b0};
                end
            end else begin
                // The offending byte is consumed by the error and not decoded.
                o_res_valid = 1'b1;
                o_res       = '{code_unit: C_REPLACEMENT, is_replacement: 1'b1};
                n_pending   = C_PEND_NONE;
            end
        end else if (!byte_in[7]) begin
            o_res_valid = 1'b1;
            o_res       = '{code_unit: {8'h00, byte_in}, is_replacement: 1'b0};
        end else if ((byte_in & C_LEAD2_MASK) == C_LEAD2_CODE) begin
            n_partial = {11'h000, byte_in[4:0]};
            n_pending = C_PEND_ONE;
        end else if ((byte_in & C_LEAD3_MASK) == C_LEAD3_CODE) begin
            n_partial = {12'h000, byte_in[3:0]};
            n_pending = C_PEND_TWO;
        end

        if (i_item.last_byte) begin
            n_partial = 16'h0000;
            n_pending = C_PEND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= 16'h0000;
            r_pending <= C_PEND_NONE;
        end else if (i_fire) begin
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

### design/u8bmp_out_reg.sv
// Result register that presents one code unit until the sink takes it.
`default_nettype none

module u8bmp_out_reg
    import u8bmp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_load,
    input  wire        i_res_valid,
    input  t_unit_item i_res,
    input  wire        i_ready,
    output logic       o_valid,
    output t_unit_item o_res
);

    logic       r_valid;
    logic       n_valid;
    t_unit_item r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // A load only happens when the register is empty or is being emptied this cycle.
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_res_valid;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

### design/utf8_to_bmp_decoder.sv
// Top level of the UTF-8 to BMP decoder.
// The decoder takes one UTF-8 byte per word and returns 16-bit code units of the basic
// multilingual plane, one word per cycle sustained while the sink holds ready. A byte is held
// in an input register, decoded by a single combinational step against the open-sequence
// state, and its code unit, if any, is placed in a result register. Lead bytes that open a
// sequence and non-final continuation bytes produce no result. Input ready drops only when
// both registers are full and the sink stalls. A non-continuation byte inside an open
// sequence yields 0xFFFD with is_replacement set; last_byte closes any open sequence.
`default_nettype none

module utf8_to_bmp_decoder
    import u8bmp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    u8bmp_byte_if.sink   i_byte,
    u8bmp_unit_if.source o_unit
);

    t_byte_item in_item;
    t_byte_item held_item;
    t_unit_item step_res;
    t_unit_item out_res;
    logic       held_valid;
    logic       step_valid;
    logic       out_valid;
    logic       advance;

    assign in_item = '{in_byte: i_byte.in_byte, last_byte: i_byte.last_byte};
    assign advance = held_valid && (!out_valid || o_unit.ready);

    u8bmp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte.valid),
        .o_ready   (i_byte.ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    u8bmp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (held_item),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    u8bmp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (step_valid),
        .i_res       (step_res),
        .i_ready     (o_unit.ready),
        .o_valid     (out_valid),
        .o_res       (out_res)
    );

    assign o_unit.valid          = out_valid;
    assign o_unit.code_unit      = out_res.code_unit;
    assign o_unit.is_replacement = out_res.is_replacement;

endmodule

`default_nettype wire

### design/u8bmp_chk.sv
// Port-level checker for the UTF-8 to BMP decoder and its bind to the top level.
`default_nettype none

module u8bmp_chk
    import u8bmp_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [15:0] i_code_unit,
    input wire        i_is_replacement
);

    // A replacement flag always travels with the replacement character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_replacement) |-> (i_code_unit == C_REPLACEMENT))
        else $error("replacement flag set without 0xFFFD");

    // Nothing is shown in the cycle after reset.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // With the output draining freely, the input never has to stall.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_ready && $past(i_out_ready) && $past(i_rst_n)) |-> i_in_ready)
        else $error("input stalled while output drains");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_code_unit) && $stable(i_is_replacement)))
        else $error("stalled output word changed");

endmodule

bind utf8_to_bmp_decoder u8bmp_chk u_u8bmp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_byte.ready),
    .i_out_valid      (o_unit.valid),
    .i_out_ready      (o_unit.ready),
    .i_code_unit      (o_unit.code_unit),
    .i_is_replacement (o_unit.is_replacement)
);

`default_nettype wire
